FILE: design/tsa_pkg.sv
// Package for the tile slot allocator: request/result item types, opcodes,
// controller states, and the controller/datapath command and status types.
// No dependencies.
package tsa_pkg;

	localparam int SIDE_LOG2_DEF     = 5;
	localparam int TILE_CAPACITY_DEF = 1024;

	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0,
		OP_FREE  = 3'd1,
		OP_TOUCH = 3'd2,
		OP_PEEK  = 3'd3,
		OP_EVICT = 3'd4,
		OP_SETC  = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic        location_valid;
		logic [4:0]  atlas_x;
		logic [4:0]  atlas_y;
		logic [7:0]  pool_index;
		logic [31:0] virtual_coord;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [4:0]  out_atlas_x;
		logic [4:0]  out_atlas_y;
		logic [7:0]  out_pool_index;
		logic [31:0] evicted_coord;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_PF1,
		ST_PF2,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_ACCEPT,
		CMD_EXEC,
		CMD_PF1,
		CMD_PF2,
		CMD_DONE
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_pf;
		logic out_free;
	} stat_t;

endpackage

FILE: design/tsa_ctrl.sv
// Controller for the tile slot allocator: sequences the clearing pass and
// the steps of each request. Depends on tsa_pkg.
module tsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  tsa_pkg::stat_t stat,
	output tsa_pkg::cmd_t  cmd,
	output logic          in_stall
);
	import tsa_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = CMD_NONE;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd = CMD_CLEAR;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd     = CMD_ACCEPT;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd     = CMD_EXEC;
				state_d = stat.need_pf ? ST_PF1 : ST_DONE;
			end
			ST_PF1: begin
				cmd     = CMD_PF1;
				state_d = ST_PF2;
			end
			ST_PF2: begin
				cmd     = CMD_PF2;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd     = CMD_DONE;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/tsa_datapath.sv
// Datapath for the tile slot allocator: free stack, link, flag and
// coordinate memories, list pointers, config and output register.
// Depends on tsa_pkg.
module tsa_datapath #(
	parameter int SIDE_LOG2     = tsa_pkg::SIDE_LOG2_DEF,
	parameter int TILE_CAPACITY = tsa_pkg::TILE_CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tsa_pkg::cmd_t      cmd,
	output tsa_pkg::stat_t     stat,
	input  tsa_pkg::in_item_t  in_data,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	output logic               out_valid,
	input  logic               out_stall,
	output tsa_pkg::out_item_t out_data
);
	import tsa_pkg::*;

	localparam int SW = $clog2(TILE_CAPACITY);
	localparam int CW = SW + 1;
	localparam logic [CW-1:0] CAP_C = CW'(TILE_CAPACITY);
	localparam logic [SW-1:0] TOP_C = SW'(TILE_CAPACITY - 1);
	localparam logic [31:0]   XMASK = (32'd1 << SIDE_LOG2) - 32'd1;

	// Memories
	logic [SW-1:0] stk_mem [TILE_CAPACITY];
	logic [SW-1:0] nxt_mem [TILE_CAPACITY];
	logic [SW-1:0] prv_mem [TILE_CAPACITY];
	logic          inr_mem [TILE_CAPACITY];
	logic [31:0]   crd_mem [TILE_CAPACITY];

	// Registers
	logic [CW-1:0] fc_q, lw_q, cnt_q;
	logic [SW-1:0] head_q, tail_q, tgt_q, clr_q;
	logic [7:0]    pool_id_q;
	in_item_t      req_q;
	logic          loc_ok_q;
	logic [SW-1:0] stk_rd_q, nxt_rd_q, prv_rd_q;
	logic          inr_rd_q;
	logic [31:0]   crd_rd_q;
	out_item_t     res_q, out_q;
	logic          out_valid_q;

	// Next values and write ports
	logic [CW-1:0] fc_d, lw_d, cnt_d;
	logic [SW-1:0] head_d, tail_d;
	out_item_t     res_d;
	logic          stk_we, nxt_we, prv_we, inr_we, crd_we;
	logic [SW-1:0] stk_wa, nxt_wa, prv_wa, inr_wa, crd_wa;
	logic [SW-1:0] stk_wd, nxt_wd, prv_wd;
	logic          inr_wd;
	logic [31:0]   crd_wd;

	// Accept-side decode
	logic [31:0]   slot32;
	logic          acc_loc_ok;
	logic [SW-1:0] acc_tgt;
	logic [CW-1:0] fc_m1;

	assign slot32     = ({27'd0, in_data.atlas_y} << SIDE_LOG2) + {27'd0, in_data.atlas_x};
	assign acc_loc_ok = in_data.location_valid && (in_data.pool_index == pool_id_q)
		&& (slot32 < 32'(TILE_CAPACITY));
	assign acc_tgt    = ((in_data.opcode == OP_PEEK) || (in_data.opcode == OP_EVICT))
		? tail_q : slot32[SW-1:0];
	assign fc_m1      = fc_q - CW'(1);

	// Split a slot into atlas column and row
	function automatic out_item_t report(input logic [SW-1:0] s, input logic [7:0] pid);
		out_item_t r;
		logic [31:0] s32, xs, ys;
		s32 = 32'(s);
		xs  = s32 & XMASK;
		ys  = s32 >> SIDE_LOG2;
		r = '0;
		r.ok             = 1'b1;
		r.out_atlas_x    = xs[4:0];
		r.out_atlas_y    = ys[4:0];
		r.out_pool_index = pid;
		return r;
	endfunction

	// Status to controller
	assign stat = '{
		clr_last: (clr_q == TOP_C),
		need_pf:  (req_q.opcode == OP_TOUCH) && loc_ok_q,
		out_free: !out_valid_q || !out_stall
	};

	// Step logic
	always_comb begin
		logic          do_unlink, do_push;
		logic [SW-1:0] s;
		logic [CW-1:0] cnt_u;
		fc_d = fc_q; lw_d = lw_q; cnt_d = cnt_q;
		head_d = head_q; tail_d = tail_q;
		res_d = res_q;
		stk_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0; inr_we = 1'b0; crd_we = 1'b0;
		stk_wa = fc_q[SW-1:0]; stk_wd = tgt_q;
		nxt_wa = prv_rd_q; nxt_wd = nxt_rd_q;
		prv_wa = nxt_rd_q; prv_wd = prv_rd_q;
		inr_wa = tgt_q; inr_wd = 1'b0;
		crd_wa = tgt_q; crd_wd = 32'd0;
		do_unlink = 1'b0; do_push = 1'b0;
		s = '0;
		cnt_u = cnt_q;
		case (cmd)
			CMD_CLEAR: begin
				inr_we = 1'b1;
				inr_wa = clr_q;
				inr_wd = 1'b0;
			end
			CMD_EXEC: begin
				res_d = '0;
				case (req_q.opcode)
					OP_ALLOC: begin
						if (fc_q != '0) begin
							s = (fc_m1 >= lw_q) ? stk_rd_q : (TOP_C - fc_m1[SW-1:0]);
							fc_d = fc_m1;
							if (fc_m1 < lw_q) lw_d = fc_m1;
							res_d = report(s, pool_id_q);
						end
					end
					OP_FREE: begin
						if (loc_ok_q) begin
							do_unlink = inr_rd_q;
							do_push   = 1'b1;
							res_d.ok  = 1'b1;
						end
					end
					OP_TOUCH: begin
						if (loc_ok_q) begin
							do_unlink = inr_rd_q;
							crd_we    = !inr_rd_q;
							res_d.ok  = 1'b1;
						end
					end
					OP_PEEK: begin
						if (cnt_q != '0) res_d = report(tail_q, pool_id_q);
					end
					OP_EVICT: begin
						if (cnt_q != '0) begin
							res_d = report(tail_q, pool_id_q);
							res_d.evicted_coord = crd_rd_q;
							do_unlink = inr_rd_q;
							do_push   = 1'b1;
						end
					end
					OP_SETC: begin
						if (loc_ok_q && inr_rd_q) begin
							crd_we   = 1'b1;
							crd_wd   = req_q.virtual_coord;
							res_d.ok = 1'b1;
						end
					end
					default: begin
					end
				endcase
				// Unlink target from the recency list
				if (do_unlink) begin
					if (tgt_q == head_q) head_d = nxt_rd_q;
					else nxt_we = 1'b1;
					if (tgt_q == tail_q) tail_d = prv_rd_q;
					else prv_we = 1'b1;
					inr_we = 1'b1;
					inr_wd = 1'b0;
					if (cnt_q != '0) cnt_u = cnt_q - CW'(1);
					cnt_d = cnt_u;
				end
				// Push target onto the free stack, drop when full
				if (do_push && (fc_q < CAP_C)) begin
					stk_we = 1'b1;
					fc_d   = fc_q + CW'(1);
				end
			end
			CMD_PF1: begin
				if (cnt_q == '0) begin
					tail_d = tgt_q;
				end else begin
					prv_we = 1'b1; prv_wa = head_q; prv_wd = tgt_q;
					nxt_we = 1'b1; nxt_wa = tgt_q;  nxt_wd = head_q;
				end
				inr_we = 1'b1;
				inr_wd = 1'b1;
			end
			CMD_PF2: begin
				prv_we = 1'b1; prv_wa = tgt_q; prv_wd = tgt_q;
				head_d = tgt_q;
				cnt_d  = cnt_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

	// Memory writes and registered reads
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (inr_we) inr_mem[inr_wa] <= inr_wd;
		if (crd_we) crd_mem[crd_wa] <= crd_wd;
		if (cmd == CMD_ACCEPT) begin
			stk_rd_q <= stk_mem[fc_m1[SW-1:0]];
			nxt_rd_q <= nxt_mem[acc_tgt];
			prv_rd_q <= prv_mem[acc_tgt];
			inr_rd_q <= inr_mem[acc_tgt];
			crd_rd_q <= crd_mem[acc_tgt];
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (cmd == CMD_ACCEPT) begin
			req_q    <= in_data;
			loc_ok_q <= acc_loc_ok;
			tgt_q    <= acc_tgt;
		end
		res_q <= res_d;
		if (cmd == CMD_DONE) out_q <= res_q;
	end

	// Control state: stack, list pointers, config, clear counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q        <= CAP_C;
			lw_q        <= CAP_C;
			cnt_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			clr_q       <= '0;
			pool_id_q   <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			fc_q   <= fc_d;
			lw_q   <= lw_d;
			cnt_q  <= cnt_d;
			head_q <= head_d;
			tail_q <= tail_d;
			if (cmd == CMD_CLEAR) clr_q <= clr_q + SW'(1);
			if (cfg_we) pool_id_q <= cfg_wdata;
			if (cmd == CMD_DONE) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: design/tile_slot_allocator_lru.sv
// Top level of the tile slot allocator: controller plus datapath.
// Depends on tsa_pkg, tsa_ctrl and tsa_datapath.
//
// Hands out slots of a square tile atlas from a LIFO free stack and keeps
// an LRU recency list of tracked slots. One request is in flight at a
// time: allocate, free, peek, evict and set-coordinate go through accept
// with the memory reads, execute and result load; a touch whose location
// is valid adds the PF1 and PF2 steps before result load, as its move to
// the list head needs more writes to the link memories. The result is
// offered from the output register after the result load step and waits
// there while the next request is accepted; while a stalled result still
// sits there, the next request holds in its load step. After reset the
// recency flag memory is cleared, one entry a cycle over all TILE_CAPACITY
// entries, while input is stalled; configuration writes are taken at any time.
module tile_slot_allocator_lru #(
	parameter int SIDE_LOG2     = tsa_pkg::SIDE_LOG2_DEF,
	parameter int TILE_CAPACITY = tsa_pkg::TILE_CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tsa_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tsa_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata
);
	import tsa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer
	tsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// Memories and state
	tsa_datapath #(
		.SIDE_LOG2     (SIDE_LOG2),
		.TILE_CAPACITY (TILE_CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
